/* rtl/bdpc_pkg.sv */
// Shared types, codes and reset values for the button debounce press classifier.
`default_nettype none

package bdpc_pkg;

    // Timer width default and configuration port geometry
    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int MS_W           = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS   = 3'd0,
        CFG_LONG_PRESS_MS = 3'd1,
        CFG_SHORT_ENABLED = 3'd2,
        CFG_LONG_ENABLED  = 3'd3,
        CFG_PRESS_ENABLED = 3'd4
    } t_cfg_index;

    // Register reset values
    localparam logic [MS_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [MS_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

    // Press machine states
    typedef enum logic [2:0] {
        ST_READY     = 3'd0,
        ST_UP        = 3'd1,
        ST_DOWN      = 3'd2,
        ST_DOWN_LONG = 3'd3,
        ST_UP_SHORT  = 3'd4,
        ST_UP_LONG   = 3'd5
    } t_press_state;

    // Event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2,
        EV_PRESS = 2'd3
    } t_event;

    // Input action codes
    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

endpackage

`default_nettype wire

/* rtl/button_debounce_press_classifier.sv */
// Top level of the button debounce and short/long press classifier.
`default_nettype none

// One request per clock cycle while o_stall is low: a millisecond tick
// carrying the raw button level, or a clear. Every request yields exactly
// one result (event code 0 none, 1 short, 2 long, 3 generic press). A
// request is registered on acceptance and classified into the output
// register once that is free, giving one request per cycle; the only
// limit is the output register, which holds its result while i_stall is
// high, and o_stall is raised only when that register and the input
// register are both occupied. Configuration writes are always taken
// (o_cfg_ready is tied high) and must be made while the block is idle.
module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic                  i_button_down,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [1:0]                 o_event_res,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CMP_W = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

    // Configuration registers
    logic [MS_W-1:0] r_debounce_ms;
    logic [MS_W-1:0] r_long_press_ms;
    logic            r_short_enabled;
    logic            r_long_enabled;
    logic            r_press_enabled;

    // Input register
    logic r_in_valid;
    logic r_in_action;
    logic r_in_down;

    // Classifier state
    t_press_state          r_state;
    t_press_state          n_state;
    logic                  r_last_level;
    logic                  n_last_level;
    logic [TIMER_BITS-1:0] r_stable_ticks;
    logic [TIMER_BITS-1:0] n_stable_ticks;
    t_event                n_event;

    // Output register
    logic   r_out_valid;
    t_event r_out_event;

    logic out_free;
    logic process;
    logic in_take;

    // Handshake: output register frees on take, input register drains into it
    assign out_free    = !r_out_valid || !i_stall;
    assign process     = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign in_take     = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_event_res = r_out_event;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_MS_RST;
            r_long_press_ms <= LONG_PRESS_MS_RST;
            r_short_enabled <= 1'b0;
            r_long_enabled  <= 1'b0;
            r_press_enabled <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:   r_debounce_ms   <= i_cfg_data[MS_W-1:0];
                CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data[MS_W-1:0];
                CFG_SHORT_ENABLED: r_short_enabled <= i_cfg_data[0];
                CFG_LONG_ENABLED:  r_long_enabled  <= i_cfg_data[0];
                CFG_PRESS_ENABLED: r_press_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_action;
            r_in_down   <= i_button_down;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_READY;
            r_last_level   <= 1'b0;
            r_stable_ticks <= '0;
        end else if (process) begin
            r_state        <= n_state;
            r_last_level   <= n_last_level;
            r_stable_ticks <= n_stable_ticks;
        end
    end

    // Debounce counter, press machine advance and event report, or clear to ready
    always_comb begin
        t_press_state st;
        logic         stable;
        logic         long_hit;

        n_last_level   = r_last_level;
        n_stable_ticks = r_stable_ticks;
        n_event        = EV_NONE;
        st             = r_state;
        stable         = 1'b0;
        long_hit       = 1'b0;

        if (r_in_action == ACT_CLEAR) begin
            st = ST_READY;
        end else begin
            // level change restarts the count, otherwise saturate upward
            if (r_in_down != r_last_level) begin
                n_last_level   = r_in_down;
                n_stable_ticks = '0;
            end else if (r_stable_ticks != {TIMER_BITS{1'b1}}) begin
                n_stable_ticks = r_stable_ticks + TIMER_BITS'(1'b1);
            end

            stable   = CMP_W'(n_stable_ticks) >= CMP_W'(r_debounce_ms);
            long_hit = CMP_W'(n_stable_ticks) > CMP_W'(r_long_press_ms);

            if (stable) begin
                case (r_state)
                    ST_READY: begin
                        if (!r_in_down) st = ST_UP;
                    end
                    ST_UP: begin
                        if (r_in_down) st = ST_DOWN;
                    end
                    ST_DOWN: begin
                        if (r_in_down && long_hit) st = ST_DOWN_LONG;
                        else if (!r_in_down)       st = ST_UP_SHORT;
                    end
                    ST_DOWN_LONG: begin
                        if (!r_in_down) st = ST_UP_LONG;
                    end
                    ST_UP_SHORT, ST_UP_LONG: ;
                    default: begin
                        // unused codes behave as ready
                        st = r_in_down ? ST_READY : ST_UP;
                    end
                endcase
            end

            // report presses (long ones once held) and return to ready
            case (st)
                ST_UP_SHORT: begin
                    n_event = r_short_enabled ? EV_SHORT :
                              (r_press_enabled ? EV_PRESS : EV_NONE);
                    st = ST_READY;
                end
                ST_DOWN_LONG, ST_UP_LONG: begin
                    n_event = r_long_enabled ? EV_LONG :
                              (r_press_enabled ? EV_PRESS : EV_NONE);
                    st = ST_READY;
                end
                ST_DOWN: begin
                    if (!r_short_enabled && !r_long_enabled) begin
                        n_event = r_press_enabled ? EV_PRESS : EV_NONE;
                        st = ST_READY;
                    end
                end
                default: ;
            endcase
        end

        n_state = st;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_event <= n_event;
        end
    end

endmodule

`default_nettype wire

/* rtl/bdpc_checker.sv */
// Port-level checker for the press classifier, bound to the top level.
`default_nettype none

module bdpc_checker
    import bdpc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_action,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_event_res,
    input wire logic       o_cfg_ready
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Upstream is only held off while a result is backed up downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a blocked result");

    // A clear request yields a no-event result once the result path is free
    a_clear_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_CLEAR) ##1 !(o_valid && i_stall)
        |=> (o_valid && o_event_res == EV_NONE))
        else $error("clear request produced an event");

    // Held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_event_res)))
        else $error("stalled result changed");

    // Configuration port never back-pressures (checked while a request is valid)
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

`default_nettype wire
